@@ src/cbts_pkg.sv @@
`default_nettype none

package cbts_pkg;

    // Bit time limits in time quanta and the prescaler limit
    localparam int unsigned MaxBitDiv   = 13;
    localparam int unsigned MinBitDiv   = 5;
    localparam int unsigned MaxPreDiv   = 1024;
    localparam int unsigned RatioLimit  = MaxPreDiv * MaxBitDiv;

    // Divider step counts for a full word and for a ratio in the search range
    localparam int unsigned WideSteps   = 32;
    localparam int unsigned NarrowSteps = 14;

    localparam logic [19:0] BrpLowMask  = 20'h0003F;
    localparam logic [19:0] BrpExtMask  = 20'hF0000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATIO,
        ST_ROUND,
        ST_CHECK,
        ST_TEST,
        ST_ACTUAL,
        ST_DONE
    } t_state;

    // Segment and SJW field for a bit time, indexed by bit time minus five
    function automatic logic [19:0] seg_entry(input logic [3:0] idx);
        logic [19:0] v;
        case (idx)
            4'd0:    v = 20'h01100;
            4'd1:    v = 20'h01200;
            4'd2:    v = 20'h02240;
            4'd3:    v = 20'h02340;
            4'd4:    v = 20'h03340;
            4'd5:    v = 20'h03440;
            4'd6:    v = 20'h03540;
            4'd7:    v = 20'h03640;
            4'd8:    v = 20'h03740;
            default: v = 20'h00000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ src/can_bit_timing_search.sv @@
// CAN bit timing search.
// Pulse start with the peripheral clock (i_source_clock) and the wanted bit
// rate (i_bit_rate); the request is taken at a clock edge where start is high
// and busy is low. busy stays high until the result has been shown.
// The result (o_timing_word, o_actual_rate, o_found) appears for exactly one
// cycle with o_valid high; the receiver must take it in that cycle, it
// cannot stall the block. Result ports hold their value until the next request.
// All arithmetic runs through one restoring divider that retires one quotient
// bit per cycle. A request runs: clock/rate, clock/ratio for the round-up,
// then up to five ratios with nine bit-time tests each, then a last 32-bit
// division for the actual rate. A zero rate or a rate above the clock skips
// the divider, and a ratio beyond the prescaler limit ends the search after
// the round-up. One request at a time.
// Reset (i_rst_n low, synchronous) aborts any request and returns to idle.
`default_nettype none

module can_bit_timing_search
    import cbts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_source_clock,
    input  wire logic [31:0] i_bit_rate,
    output logic             o_valid,
    output logic [19:0]      o_timing_word,
    output logic [31:0]      o_actual_rate,
    output logic             o_found
);

    localparam logic [31:0] LimitW = 32'(RatioLimit);
    localparam logic [5:0]  StepsW = 6'(WideSteps);
    localparam logic [5:0]  StepsN = 6'(NarrowSteps);
    localparam logic [3:0]  BitsMax = 4'(MaxBitDiv);
    localparam logic [3:0]  BitsMin = 4'(MinBitDiv);

    t_state      r_state, n_state;
    logic [31:0] r_clk, n_clk;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_ratio, n_ratio;
    logic [3:0]  r_bits, n_bits;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic [5:0]  r_cnt, n_cnt;
    logic [19:0] r_word, n_word;
    logic [31:0] r_actual, n_actual;
    logic        r_found, n_found;

    logic        div_done;
    logic        bad_req;
    logic        test_hit;
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [32:0] rem_sub;
    logic [11:0] pre_m1;
    logic [19:0] word_v;

    // Divider step: shift in the next dividend bit, subtract when it fits
    assign rem_sh   = {r_rem, r_quo[31]};
    assign rem_ge   = rem_sh >= {1'b0, r_dvs};
    assign rem_sub  = rem_sh - {1'b0, r_dvs};
    assign div_done = (r_cnt == 6'd0);

    assign bad_req  = (i_bit_rate == 32'd0) || (i_bit_rate > i_source_clock);
    assign test_hit = (r_rem == 32'd0) && (r_quo != 32'd0);

    // Pack prescaler minus one with the segment entry of this bit time
    assign pre_m1 = r_quo[11:0] - 12'd1;
    assign word_v = seg_entry(r_bits - BitsMin)
                  | ({8'd0, pre_m1} & BrpLowMask)
                  | ({pre_m1[9:0], 10'd0} & BrpExtMask);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = bad_req ? ST_DONE : ST_RATIO;
                end
            end
            ST_RATIO: begin
                if (div_done) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (div_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = (r_ratio > LimitW) ? ST_DONE : ST_TEST;
            end
            ST_TEST: begin
                if (div_done) begin
                    if (test_hit) begin
                        n_state = ST_ACTUAL;
                    end else if (r_bits == BitsMin) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_ACTUAL: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath controls and divider loads
    always_comb begin
        n_clk    = r_clk;
        n_rate   = r_rate;
        n_ratio  = r_ratio;
        n_bits   = r_bits;
        n_word   = r_word;
        n_actual = r_actual;
        n_found  = r_found;
        n_dvs    = r_dvs;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_cnt    = r_cnt;

        // advance the divider while it has steps left
        if (!div_done) begin
            n_quo = {r_quo[30:0], rem_ge};
            n_rem = rem_ge ? rem_sub[31:0] : rem_sh[31:0];
            n_cnt = r_cnt - 6'd1;
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_clk    = i_source_clock;
                    n_rate   = i_bit_rate;
                    n_word   = 20'd0;
                    n_actual = 32'd0;
                    n_found  = 1'b0;
                    n_quo    = i_source_clock;
                    n_rem    = 32'd0;
                    n_dvs    = i_bit_rate;
                    n_cnt    = bad_req ? 6'd0 : StepsW;
                end
            end
            ST_RATIO: begin
                // hold the ratio, then divide the clock by it
                if (div_done) begin
                    n_ratio = r_quo;
                    n_quo   = r_clk;
                    n_rem   = 32'd0;
                    n_dvs   = r_quo;
                    n_cnt   = StepsW;
                end
            end
            ST_ROUND: begin
                // round the ratio up when the rate would exceed the request
                if (div_done && (r_quo > r_rate)) begin
                    n_ratio = r_ratio + 32'd1;
                end
            end
            ST_CHECK: begin
                n_bits = BitsMax;
                n_quo  = {r_ratio[13:0], 18'd0};
                n_rem  = 32'd0;
                n_dvs  = {28'd0, BitsMax};
                n_cnt  = (r_ratio > LimitW) ? 6'd0 : StepsN;
            end
            ST_TEST: begin
                if (div_done) begin
                    if (test_hit) begin
                        n_word = word_v;
                        n_quo  = r_clk;
                        n_rem  = 32'd0;
                        n_dvs  = r_ratio;
                        n_cnt  = StepsW;
                    end else if (r_bits == BitsMin) begin
                        n_ratio = r_ratio + 32'd1;
                    end else begin
                        n_bits = r_bits - 4'd1;
                        n_quo  = {r_ratio[13:0], 18'd0};
                        n_rem  = 32'd0;
                        n_dvs  = {28'd0, r_bits - 4'd1};
                        n_cnt  = StepsN;
                    end
                end
            end
            ST_ACTUAL: begin
                if (div_done) begin
                    n_actual = r_quo;
                    n_found  = 1'b1;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_clk    <= n_clk;
        r_rate   <= n_rate;
        r_ratio  <= n_ratio;
        r_bits   <= n_bits;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_word   <= n_word;
        r_actual <= n_actual;
        r_found  <= n_found;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_DONE);
    assign o_timing_word = r_word;
    assign o_actual_rate = r_actual;
    assign o_found       = r_found;

    // Checks
    a_found_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_timing_word != 20'd0))
        else $error("found result with zero timing word");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> ((o_timing_word == 20'd0) && (o_actual_rate == 32'd0)))
        else $error("not-found result carries nonzero fields");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_take_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken without going busy");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= StepsW)
        else $error("divider step count out of range");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
module testbench;
    import cbts_pkg::*;

    // Idle cycles allowed with no request or result accepted
    localparam int unsigned WatchdogLimit = 5000;
    // Quiet cycles after the last result, about one worst-case search
    localparam int unsigned DrainCycles   = 1000;
    localparam int unsigned RandomItems   = 600;
    // Items at the end that go out back to back
    localparam int unsigned SteadyTail    = 80;

    // One timing request and the result it should produce
    typedef struct packed {
        logic [31:0] clk_hz;
        logic [31:0] rate_hz;
        logic [19:0] word;
        logic [31:0] actual;
        logic        found;
    } timing_t;

    // Directed row: result typed in when known is set, else predicted
    typedef struct packed {
        logic    known;
        timing_t want;
    } stim_row_t;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic [31:0] i_source_clock = '0;
    logic [31:0] i_bit_rate     = '0;
    logic        busy;
    logic        o_valid;
    logic [19:0] o_timing_word;
    logic [31:0] o_actual_rate;
    logic        o_found;

    timing_t     pending_timings[$];
    stim_row_t   directed_rows[$];
    timing_t     offered_timing = '0;
    timing_t     oldest_timing;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;

    can_bit_timing_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_source_clock(i_source_clock),
        .i_bit_rate    (i_bit_rate),
        .o_valid       (o_valid),
        .o_timing_word (o_timing_word),
        .o_actual_rate (o_actual_rate),
        .o_found       (o_found)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Round the clock ratio up, then walk upward for the first exact bit time
    function automatic timing_t predict_timing(input logic [31:0] clk_hz,
                                               input logic [31:0] rate_hz);
        timing_t     t;
        logic [31:0] ratio;
        logic [31:0] pre;
        logic [31:0] seg;
        int unsigned bits;
        bit          hit;
        t         = '0;
        t.clk_hz  = clk_hz;
        t.rate_hz = rate_hz;
        hit       = 1'b0;
        if (rate_hz != 32'd0 && rate_hz <= clk_hz) begin
            ratio = clk_hz / rate_hz;
            if (clk_hz / ratio > rate_hz) ratio = ratio + 32'd1;
            while (!hit && ratio <= RatioLimit) begin
                for (bits = MaxBitDiv; bits >= MinBitDiv && !hit; bits--) begin
                    pre = ratio / bits;
                    if (pre != 32'd0 && pre * bits == ratio) begin
                        case (bits)
                            13:      seg = 32'h3740;
                            12:      seg = 32'h3640;
                            11:      seg = 32'h3540;
                            10:      seg = 32'h3440;
                            9:       seg = 32'h3340;
                            8:       seg = 32'h2340;
                            7:       seg = 32'h2240;
                            6:       seg = 32'h1200;
                            default: seg = 32'h1100;
                        endcase
                        seg = seg | ((pre - 32'd1) & 32'(BrpLowMask))
                                  | (((pre - 32'd1) << 10) & 32'(BrpExtMask));
                        t.word   = seg[19:0];
                        t.actual = clk_hz / ratio;
                        t.found  = 1'b1;
                        hit      = 1'b1;
                    end
                end
                if (!hit) ratio = ratio + 32'd1;
            end
        end
        return t;
    endfunction

    task automatic flag_mismatch(input string what, input timing_t req,
                                 input logic [31:0] got, input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH %s clk=%0d rate=%0d: got %0h want %0h",
                 what, req.clk_hz, req.rate_hz, got, want);
    endtask

    task automatic add_row(input logic [31:0] clk_hz, input logic [31:0] rate_hz,
                           input logic known, input logic [19:0] word,
                           input logic [31:0] actual, input logic found);
        stim_row_t r;
        r.known        = known;
        r.want.clk_hz  = clk_hz;
        r.want.rate_hz = rate_hz;
        r.want.word    = word;
        r.want.actual  = actual;
        r.want.found   = found;
        directed_rows.push_back(r);
    endtask

    // Offer one request, optionally after an idle burst, and hold it until taken
    task automatic send_request(input timing_t want, input int unsigned idle_odds);
        if (idle_odds != 0 && $urandom_range(0, 9) < idle_odds) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_source_clock <= want.clk_hz;
        i_bit_rate     <= want.rate_hz;
        offered_timing <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Record accepted requests, check results against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_timings.size() == 0) begin
                    oldest_timing = '0;
                    flag_mismatch("unexpected result", oldest_timing,
                                  32'(o_timing_word), 32'd0);
                end else begin
                    oldest_timing = pending_timings.pop_front();
                    if (o_timing_word !== oldest_timing.word)
                        flag_mismatch("timing_word", oldest_timing,
                                      32'(o_timing_word), 32'(oldest_timing.word));
                    if (o_actual_rate !== oldest_timing.actual)
                        flag_mismatch("actual_rate", oldest_timing,
                                      o_actual_rate, oldest_timing.actual);
                    if (o_found !== oldest_timing.found)
                        flag_mismatch("found", oldest_timing,
                                      32'(o_found), 32'(oldest_timing.found));
                end
            end
            if (start && !busy) pending_timings.push_back(offered_timing);
            if ((start && !busy) || o_valid) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= WatchdogLimit) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int unsigned mode;
        int unsigned ratio_t;
        int unsigned width;
        int unsigned idle_odds;
        logic [31:0] rate;
        logic [31:0] clk_hz;
        logic [31:0] mask;
        logic [31:0] rate_cap;
        logic [63:0] clk_wide;

        // Zero rate, rate above clock, ratio past the limit: all not found
        add_row(32'd0,          32'd0,          1'b1, 20'h0, 32'd0, 1'b0);
        add_row(32'd0,          32'd1,          1'b1, 20'h0, 32'd0, 1'b0);
        add_row(32'd1,          32'd0,          1'b1, 20'h0, 32'd0, 1'b0);
        add_row(32'hFFFFFFFF,   32'd0,          1'b1, 20'h0, 32'd0, 1'b0);
        add_row(32'd5,          32'd6,          1'b1, 20'h0, 32'd0, 1'b0);
        add_row(32'hFFFFFFFF,   32'd1,          1'b1, 20'h0, 32'd0, 1'b0);
        add_row(32'd13313,      32'd1,          1'b1, 20'h0, 32'd0, 1'b0);
        // Ratio exactly at the limit: largest prescaler with a 13 quanta bit
        add_row(32'd13312,      32'd1,          1'b1, 20'hF377F, 32'd1, 1'b1);
        add_row(32'd8000000,    32'd500000,     1'b1, 20'h02341, 32'd500000, 1'b1);
        // Rows checked against the predictor
        add_row(32'hFFFFFFFF,   32'hFFFFFFFF,   1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'hFFFFFFFF,   32'hFFFFFFFE,   1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'h80000000,   32'h7FFFFFFF,   1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'd1,          32'd1,          1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'd7,          32'd1,          1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'd100,        32'd30,         1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'd13311,      32'd1,          1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'hFFFFFFFF,   32'd322638,     1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'hFFFFFFFF,   32'd322637,     1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'd36000000,   32'd1000000,    1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'd48000000,   32'd1000000,    1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'd16000000,   32'd125000,     1'b0, 20'h0, 32'd0, 1'b0);
        add_row(32'd80000000,   32'd10000,      1'b0, 20'h0, 32'd0, 1'b0);

        // Hold reset low, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[k]) begin
            if (directed_rows[k].known) begin
                send_request(directed_rows[k].want, 3);
            end else begin
                send_request(predict_timing(directed_rows[k].want.clk_hz,
                                            directed_rows[k].want.rate_hz), 3);
            end
        end

        // Random requests, mostly with a ratio inside the search range
        idle_odds = 3;
        for (int unsigned n = 0; n < RandomItems; n++) begin
            if (n % 50 == 0) idle_odds = $urandom_range(0, 4);
            if (n >= RandomItems - SteadyTail) idle_odds = 0;
            mode = $urandom_range(0, 99);
            if (mode < 60 || mode >= 90) begin
                if (mode >= 90) begin
                    ratio_t = RatioLimit - 12 + $urandom_range(0, 24);
                end else if ($urandom_range(0, 4) != 0) begin
                    ratio_t = $urandom_range(1, 200);
                end else begin
                    ratio_t = $urandom_range(1, RatioLimit + 20);
                end
                width    = $urandom_range(1, 32);
                mask     = (width == 32) ? 32'hFFFFFFFF : ((32'd1 << width) - 32'd1);
                rate     = $urandom & mask;
                rate_cap = 32'hFFFFFFFF / (ratio_t + 1);
                if (rate > rate_cap) rate = rate % rate_cap + 32'd1;
                if (rate == 32'd0) rate = 32'd1;
                clk_wide = 64'(rate) * 64'(ratio_t) + 64'($urandom_range(0, rate - 32'd1));
                clk_hz   = clk_wide[31:0];
            end else if (mode < 75) begin
                clk_hz = $urandom;
                rate   = $urandom;
            end else if (mode < 85) begin
                clk_hz = $urandom;
                rate   = (clk_hz >> $urandom_range(0, 15)) + 32'($urandom_range(0, 1));
            end else begin
                clk_hz = $urandom;
                case ($urandom_range(0, 2))
                    0:       rate = 32'd0;
                    1:       rate = clk_hz;
                    default: rate = clk_hz + 32'd1;
                endcase
            end
            send_request(predict_timing(clk_hz, rate), idle_odds);
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_timings.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/cbts_pkg.sv
src/can_bit_timing_search.sv
bench/testbench.sv
